// ===== design/estop_pkg.sv =====
// ----------------------------------------------------------------------------
// estop_pkg
// Shared widths, codes and constants of the e-stop command packet deframer.
// ----------------------------------------------------------------------------
package estop_pkg;

  localparam int BYTE_W = 8;
  localparam int SEQ_W  = 16;
  localparam int POS_W  = 3;
  localparam int PHASE_W = 2;

  // Reset value of the start marker register: ASCII 'f'.
  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h66;

  // The only length byte that is accepted.
  localparam logic [BYTE_W-1:0] PACKET_LENGTH = 8'd7;

  // The check byte is this value minus the low byte of the running sum.
  localparam logic [BYTE_W-1:0] CHECK_BASE = 8'hFF;

  // Parser phases.
  localparam logic [PHASE_W-1:0] PH_HUNT    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COLLECT = 2'd2;

  // Byte positions within a packet.
  localparam logic [POS_W-1:0] POS_NONE   = 3'd0;
  localparam logic [POS_W-1:0] POS_LENGTH = 3'd1;
  localparam logic [POS_W-1:0] POS_ESTOP  = 3'd2;
  localparam logic [POS_W-1:0] POS_LIGHT  = 3'd3;
  localparam logic [POS_W-1:0] POS_SEQ_LO = 3'd4;
  localparam logic [POS_W-1:0] POS_SEQ_HI = 3'd5;
  localparam logic [POS_W-1:0] POS_CHECK  = 3'd6;

endpackage

// ===== design/estop_if.sv =====
// ----------------------------------------------------------------------------
// estop_if
// Valid/ready channels of the deframer: received bytes, decoded packets and
// the start marker register write.
// ----------------------------------------------------------------------------
interface estop_in_if;
  logic                           valid;
  logic                           ready;
  logic [estop_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface estop_out_if;
  logic                           valid;
  logic                           ready;
  logic [estop_pkg::BYTE_W-1:0]   estop_code;
  logic [estop_pkg::BYTE_W-1:0]   light_code;
  logic [estop_pkg::SEQ_W-1:0]    sequence_number;
  logic                           relay_drive;
  logic                           lamp_drive;

  modport source (output valid, output estop_code, output light_code,
                  output sequence_number, output relay_drive, output lamp_drive,
                  input ready);
  modport sink   (input valid, input estop_code, input light_code,
                  input sequence_number, input relay_drive, input lamp_drive,
                  output ready);
endinterface

interface estop_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [estop_pkg::BYTE_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/estop_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// estop_packet_deframer
// Finds seven-byte e-stop command packets in a received byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while not stalled and
// returns one request on the result channel for every valid packet: start
// marker, length 7, e-stop byte, light byte, sequence number (low byte
// first) and a check byte equal to 0xFF minus the low byte of the sum of
// the six bytes before it. A byte is registered on arrival and parsed from
// the input register; a finished result is then registered in the result
// register and offered from there. The sustained rate is one byte per cycle
// while the result side does not hold the parser back.
// Input and result registers decouple the two sides: a byte is still taken
// while a finished result waits, and the parser only pauses when a result
// is waiting and the result register cannot be freed. Failed packets leave
// no trace on the result channel. The start marker is written over the
// configuration channel, which is always ready, and resets to ASCII 'f'.
// ----------------------------------------------------------------------------
module estop_packet_deframer (
  input  logic               clk,
  input  logic               rst_n,
  estop_in_if.sink           in_chan,
  estop_out_if.source        out_chan,
  estop_cfg_if.sink          cfg_chan
);

  // Configuration register.
  logic [estop_pkg::BYTE_W-1:0]  start_marker_r;

  // Input register.
  logic                          in_valid_r;
  logic [estop_pkg::BYTE_W-1:0]  in_byte_r;

  // Parser state.
  logic [estop_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [estop_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [estop_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [estop_pkg::BYTE_W-1:0]  estop_r, estop_nxt;
  logic [estop_pkg::BYTE_W-1:0]  light_r, light_nxt;
  logic [estop_pkg::SEQ_W-1:0]   seq_r, seq_nxt;

  // Result register.
  logic                          out_valid_r;
  logic [estop_pkg::BYTE_W-1:0]  out_estop_r;
  logic [estop_pkg::BYTE_W-1:0]  out_light_r;
  logic [estop_pkg::SEQ_W-1:0]   out_seq_r;

  logic                          proc_go;
  logic                          result_ok;
  logic [estop_pkg::BYTE_W-1:0]  expected;

  // The parser advances when a byte is held and the result register is
  // either empty or being emptied in this cycle.
  assign proc_go         = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready   = !in_valid_r || proc_go;
  assign cfg_chan.ready  = 1'b1;

  assign expected = estop_pkg::CHECK_BASE - sum_r;

  // Next state of the parser for the byte held in the input register.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    estop_nxt = estop_r;
    light_nxt = light_r;
    seq_nxt   = seq_r;
    result_ok = 1'b0;
    case (phase_r)
      estop_pkg::PH_HUNT: begin
        if (in_byte_r == start_marker_r) begin
          phase_nxt = estop_pkg::PH_LENGTH;
          pos_nxt   = estop_pkg::POS_LENGTH;
          sum_nxt   = in_byte_r;
        end
      end
      estop_pkg::PH_LENGTH: begin
        // A bad length byte is dropped; it is not tried as a start marker.
        if (in_byte_r != estop_pkg::PACKET_LENGTH) begin
          phase_nxt = estop_pkg::PH_HUNT;
          pos_nxt   = estop_pkg::POS_NONE;
          sum_nxt   = '0;
        end else begin
          phase_nxt = estop_pkg::PH_COLLECT;
          pos_nxt   = estop_pkg::POS_ESTOP;
          sum_nxt   = sum_r + in_byte_r;
        end
      end
      estop_pkg::PH_COLLECT: begin
        if (pos_r == estop_pkg::POS_CHECK) begin
          phase_nxt = estop_pkg::PH_HUNT;
          pos_nxt   = estop_pkg::POS_NONE;
          sum_nxt   = '0;
          result_ok = (in_byte_r == expected);
        end else begin
          sum_nxt = sum_r + in_byte_r;
          pos_nxt = pos_r + 3'd1;
          case (pos_r)
            estop_pkg::POS_ESTOP:  estop_nxt = in_byte_r;
            estop_pkg::POS_LIGHT:  light_nxt = in_byte_r;
            estop_pkg::POS_SEQ_LO: seq_nxt   = {seq_r[15:8], in_byte_r};
            default:               seq_nxt   = {in_byte_r, seq_r[7:0]};
          endcase
        end
      end
      default: begin
        phase_nxt = estop_pkg::PH_HUNT;
        pos_nxt   = estop_pkg::POS_NONE;
        sum_nxt   = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= estop_pkg::START_MARKER_RESET;
      in_valid_r     <= 1'b0;
      phase_r        <= estop_pkg::PH_HUNT;
      pos_r          <= estop_pkg::POS_NONE;
      sum_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        start_marker_r <= cfg_chan.data;
      end
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (proc_go) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        sum_r   <= sum_nxt;
      end
      if (proc_go) begin
        out_valid_r <= result_ok;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.rx_byte;
    end
    if (proc_go) begin
      estop_r <= estop_nxt;
      light_r <= light_nxt;
      seq_r   <= seq_nxt;
    end
    if (proc_go && result_ok) begin
      out_estop_r <= estop_r;
      out_light_r <= light_r;
      out_seq_r   <= seq_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.estop_code      = out_estop_r;
  assign out_chan.light_code      = out_light_r;
  assign out_chan.sequence_number = out_seq_r;
  assign out_chan.relay_drive     = (out_estop_r == '0);
  assign out_chan.lamp_drive      = (out_light_r == '0);

  // While hunting, the position and running sum stay cleared.
  a_hunt_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == estop_pkg::PH_HUNT) |-> (pos_r == estop_pkg::POS_NONE && sum_r == '0))
    else $error("hunt phase with stale position or sum");

  // The length phase always sits at the length position.
  a_length_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == estop_pkg::PH_LENGTH) |-> (pos_r == estop_pkg::POS_LENGTH))
    else $error("length phase at wrong position");

  // Collection stays between the e-stop byte and the check byte.
  a_collect_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == estop_pkg::PH_COLLECT) |->
      (pos_r >= estop_pkg::POS_ESTOP && pos_r <= estop_pkg::POS_CHECK))
    else $error("collect phase position out of range");

  // A passing check byte always lands in the result register.
  a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && result_ok) |=> out_valid_r)
    else $error("valid packet lost");

endmodule

// ===== verif/estop_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estop_packet_deframer_tb
// Self-checking bench for the e-stop command packet deframer.
// ----------------------------------------------------------------------------
// Byte streams are offered on the input channel with random gaps. Each
// accepted byte is passed through a local copy of the packet parser, which
// queues the fields that a valid packet should produce. Every request on the
// result channel is compared field by field with the oldest queued packet.
// The run covers hand-picked corner cases, every start marker extreme and a
// long random stream, with one long result hold-off that stalls the input.
// ----------------------------------------------------------------------------
module estop_packet_deframer_tb;

  localparam longint TIMEOUT_NS   = 64'd10_000_000;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     DRAIN_LIMIT  = 2000;
  localparam int     PHASE_BYTES  = 300;
  localparam int     HOLD_OFF     = 300;
  localparam int     REPORT_CAP   = 100;

  // Fields of one decoded packet, in the order the result channel carries them.
  typedef struct packed {
    logic [estop_pkg::BYTE_W-1:0] estop_code;
    logic [estop_pkg::BYTE_W-1:0] light_code;
    logic [estop_pkg::SEQ_W-1:0]  sequence_number;
    logic                         relay_drive;
    logic                         lamp_drive;
  } packet_fields_t;

  logic clk;
  logic rst_n;

  estop_in_if  in_if ();
  estop_out_if out_if ();
  estop_cfg_if cfg_if ();

  estop_packet_deframer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Local copy of the parser state and of the start marker register.
  logic [estop_pkg::BYTE_W-1:0]  marker_value;
  logic [estop_pkg::PHASE_W-1:0] parse_phase;
  logic [estop_pkg::POS_W-1:0]   byte_pos;
  logic [estop_pkg::BYTE_W-1:0]  byte_sum;
  logic [estop_pkg::BYTE_W-1:0]  held_estop;
  logic [estop_pkg::BYTE_W-1:0]  held_light;
  logic [estop_pkg::SEQ_W-1:0]   held_seq;

  // Packets that the block still owes us, oldest first.
  packet_fields_t pending_packets[$];

  int error_count;
  int bytes_sent;
  int packets_checked;
  int marker_writes;
  int input_stall_cycles;

  // Knobs shared between the stimulus and the result receiver.
  bit idle_on;
  int hold_off_req;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // One line per mismatch; the count goes on past the print cap.
  task automatic report(input string msg);
    if (error_count < REPORT_CAP) begin
      $display("tb: mismatch at %0t ns: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Packet parser used for prediction. It follows the block byte by byte and
  // queues the fields of every packet whose check byte is correct.
  // --------------------------------------------------------------------------
  task automatic restart_hunt();
    parse_phase = estop_pkg::PH_HUNT;
    byte_pos    = estop_pkg::POS_NONE;
    byte_sum    = '0;
  endtask

  task automatic deframe_byte(input logic [estop_pkg::BYTE_W-1:0] b);
    packet_fields_t               pkt;
    logic [estop_pkg::BYTE_W-1:0] want_check;
    case (parse_phase)
      estop_pkg::PH_HUNT: begin
        if (b == marker_value) begin
          parse_phase = estop_pkg::PH_LENGTH;
          byte_pos    = estop_pkg::POS_LENGTH;
          byte_sum    = b;
        end
      end
      estop_pkg::PH_LENGTH: begin
        // A wrong length drops straight back to the hunt; the byte itself is
        // not looked at again as a possible start marker.
        if (b != estop_pkg::PACKET_LENGTH) begin
          restart_hunt();
        end else begin
          parse_phase = estop_pkg::PH_COLLECT;
          byte_pos    = estop_pkg::POS_ESTOP;
          byte_sum    = byte_sum + b;
        end
      end
      estop_pkg::PH_COLLECT: begin
        if (byte_pos < estop_pkg::POS_CHECK) begin
          case (byte_pos)
            estop_pkg::POS_ESTOP:  held_estop = b;
            estop_pkg::POS_LIGHT:  held_light = b;
            estop_pkg::POS_SEQ_LO: held_seq[7:0] = b;
            default:               held_seq[15:8] = b;
          endcase
          byte_sum = byte_sum + b;
          byte_pos = byte_pos + 1'b1;
        end else begin
          want_check = estop_pkg::CHECK_BASE - byte_sum;
          restart_hunt();
          if (b == want_check) begin
            pkt.estop_code      = held_estop;
            pkt.light_code      = held_light;
            pkt.sequence_number = held_seq;
            pkt.relay_drive     = (held_estop == '0);
            pkt.lamp_drive      = (held_light == '0);
            pending_packets.push_back(pkt);
          end
        end
      end
      default: restart_hunt();
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge; a request completes at a
  // rising edge with valid and ready both high.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid stays high from one byte to the next unless a gap is drawn, so it
  // is never lowered and raised within the same time step.
  task automatic send_byte(input logic [estop_pkg::BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // A spoilt check byte differs from the right one in at least one bit.
  task automatic send_packet(input logic [estop_pkg::BYTE_W-1:0] estop,
                             input logic [estop_pkg::BYTE_W-1:0] light,
                             input logic [estop_pkg::SEQ_W-1:0] seq_no,
                             input bit spoil_check);
    logic [estop_pkg::BYTE_W-1:0] sum;
    logic [estop_pkg::BYTE_W-1:0] chk;
    sum = marker_value + estop_pkg::PACKET_LENGTH + estop + light
          + seq_no[7:0] + seq_no[15:8];
    chk = estop_pkg::CHECK_BASE - sum;
    if (spoil_check) chk = chk ^ estop_pkg::BYTE_W'($urandom_range(1, 255));
    send_byte(marker_value);
    send_byte(estop_pkg::PACKET_LENGTH);
    send_byte(estop);
    send_byte(light);
    send_byte(seq_no[7:0]);
    send_byte(seq_no[15:8]);
    send_byte(chk);
  endtask

  // Zero often enough to exercise the drive outputs, all ones now and then.
  function automatic logic [estop_pkg::BYTE_W-1:0] field_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 33) return '1;
    return estop_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // Lower valid, wait for every owed packet, then let the parser settle on
  // any trailing bytes that produce no result.
  task automatic wait_for_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_packets.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (pending_packets.size() != 0) begin
      report($sformatf("no result for packet with sequence %04h",
                       pending_packets[0].sequence_number));
      void'(pending_packets.pop_front());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The marker register is only written with the block idle.
  task automatic write_marker(input logic [estop_pkg::BYTE_W-1:0] value);
    wait_for_idle();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    marker_value = value;
    marker_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result receiver. Ready is drawn afresh on each falling edge: mostly high,
  // with short stalls and the odd long one. A hold-off request from the
  // stimulus keeps ready low for a stretch whose length the request sets.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int n;
    int r;
    int stall_left;
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        n            = hold_off_req;
        hold_off_req = 0;
        out_if.ready = 1'b0;
        while (n > 0) begin
          @(negedge clk);
          n--;
        end
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (!idle_on) begin
        out_if.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_if.ready = 1'b1;
        end else begin
          out_if.ready = 1'b0;
          stall_left   = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every completed result request is matched against the
  // oldest packet still owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    packet_fields_t want;
    if (rst_n && in_if.valid && !in_if.ready) input_stall_cycles++;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_packets.size() == 0) begin
        report($sformatf("unexpected result, sequence %04h", out_if.sequence_number));
      end else begin
        want = pending_packets.pop_front();
        packets_checked++;
        if (out_if.estop_code !== want.estop_code)
          report($sformatf("estop_code %02h, want %02h", out_if.estop_code, want.estop_code));
        if (out_if.light_code !== want.light_code)
          report($sformatf("light_code %02h, want %02h", out_if.light_code, want.light_code));
        if (out_if.sequence_number !== want.sequence_number)
          report($sformatf("sequence_number %04h, want %04h",
                           out_if.sequence_number, want.sequence_number));
        if (out_if.relay_drive !== want.relay_drive)
          report($sformatf("relay_drive %b, want %b", out_if.relay_drive, want.relay_drive));
        if (out_if.lamp_drive !== want.lamp_drive)
          report($sformatf("lamp_drive %b, want %b", out_if.lamp_drive, want.lamp_drive));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Corner cases at the reset marker: all-zero and all-ones fields, a bad
  // length (including a marker standing in the length slot, which must not
  // reopen a packet), markers inside a packet and a failed check byte.
  task automatic test_directed_packets();
    send_packet('0, '0, '0, 1'b0);
    send_byte(marker_value);
    send_byte('0);
    send_byte(marker_value);
    send_byte(marker_value);
    send_packet('1, marker_value, {marker_value, 8'hFF}, 1'b0);
    send_packet(8'h12, 8'h34, 16'h5678, 1'b1);
    wait_for_idle();
  endtask

  // Both extremes of the start marker, each with a good and a spoilt packet.
  task automatic test_marker_extremes();
    write_marker('0);
    send_packet('0, field_byte(), estop_pkg::SEQ_W'($urandom), 1'b0);
    send_packet(field_byte(), '0, estop_pkg::SEQ_W'($urandom), 1'b1);
    write_marker('1);
    send_packet('1, field_byte(), estop_pkg::SEQ_W'($urandom), 1'b0);
    send_packet(field_byte(), field_byte(), estop_pkg::SEQ_W'($urandom), 1'b1);
  endtask

  // Mostly well-formed packets with random content, mixed with spoilt check
  // bytes, wrong lengths and loose noise. One phase runs without idling.
  task automatic test_random_traffic();
    logic [estop_pkg::BYTE_W-1:0] markers[4];
    logic [estop_pkg::BYTE_W-1:0] b;
    int first;
    int r;
    markers[0] = estop_pkg::START_MARKER_RESET;
    markers[1] = '0;
    markers[2] = '1;
    markers[3] = estop_pkg::BYTE_W'($urandom_range(1, 254));
    for (int p = 0; p < 4; p++) begin
      write_marker(markers[p]);
      idle_on = (p != 2);
      first   = bytes_sent;
      while (bytes_sent - first < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_packet(field_byte(), field_byte(), estop_pkg::SEQ_W'($urandom), 1'b0);
        end else if (r < 80) begin
          send_packet(field_byte(), field_byte(), estop_pkg::SEQ_W'($urandom), 1'b1);
        end else if (r < 88) begin
          send_byte(marker_value);
          do b = estop_pkg::BYTE_W'($urandom_range(0, 255));
          while (b == estop_pkg::PACKET_LENGTH);
          send_byte(b);
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(estop_pkg::BYTE_W'($urandom_range(0, 255)));
        end
      end
    end
    idle_on = 1'b1;
    wait_for_idle();
  endtask

  // The receiver holds off for a long stretch while packets keep coming, so
  // the result and input registers fill and the input channel stalls.
  task automatic test_back_pressure();
    idle_on      = 1'b0;
    hold_off_req = HOLD_OFF;
    repeat (12) send_packet(field_byte(), field_byte(), estop_pkg::SEQ_W'($urandom), 1'b0);
    wait_for_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    idle_on       = 1'b1;
    hold_off_req  = 0;
    error_count   = 0;
    bytes_sent    = 0;
    packets_checked    = 0;
    marker_writes      = 0;
    input_stall_cycles = 0;

    marker_value = estop_pkg::START_MARKER_RESET;
    held_estop   = '0;
    held_light   = '0;
    held_seq     = '0;
    restart_hunt();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_packets();
    test_marker_extremes();
    test_back_pressure();
    test_random_traffic();

    $display("tb: %0d bytes sent, %0d packets checked, %0d start marker writes",
             bytes_sent, packets_checked, marker_writes);
    $display("tb: input stalled for %0d cycles, %0d mismatches",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/estop_pkg.sv
design/estop_if.sv
design/estop_packet_deframer.sv
verif/estop_packet_deframer_tb.sv
